>>> sv/ioq_pkg.sv
`default_nettype none
package ioq_pkg;

  localparam int COORD_W            = 32;
  localparam int DEF_STORE_DEPTH    = 64;
  localparam int DEF_MAX_COMPONENTS = 8;
  // components longer than this are searched, shorter ones scanned
  localparam int LONG_COMPONENT     = 15;

  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 2 * COORD_W;

  localparam logic [IN_TUSER_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [IN_TUSER_W-1:0] OP_QUERY = 2'd1;
  localparam logic [IN_TUSER_W-1:0] OP_CLEAR = 2'd2;

  // one stored interval plus its running max end
  typedef struct packed {
    logic [COORD_W-1:0] ent_start;
    logic [COORD_W-1:0] ent_end;
    logic [COORD_W-1:0] ent_rmax;
  } entry_t;

endpackage
`default_nettype wire

>>> sv/interval_overlap_query_top.sv
`default_nettype none
// Interval overlap query block.
// Input channel (in_*): one request per handshake. in_tuser carries the
// operation (load, query, clear); in_tlast marks the last entry of a
// component on a load. in_tdata carries entry start/end and query start/end.
// Loads and clears complete in the cycle they are accepted.
// A query walks the stored components in load order. For each component it
// fetches the descriptor, then scans every entry of a short component
// (length <= 15) upward; a long one is binary-searched and then walked
// back downward entry by entry. The end-of-list check and the final
// response close the query. All steps read the entry store, one read
// a cycle.
// in_tready is low while a query runs; the next request waits for it.
// Output channel (out_*): one response per match, out_tlast on the final
// one; a query without overlap gives one response with found = 0.
// A receiver stall (out_tready low) holds the output register and freezes
// the walk once one further match is parked in the holding stage.
// Reset (rst_n low, synchronous) empties the store and the component list
// and drops any query in flight. No clearing pass is needed.
module interval_overlap_query_top #(
  parameter int STORE_DEPTH    = ioq_pkg::DEF_STORE_DEPTH,
  parameter int MAX_COMPONENTS = ioq_pkg::DEF_MAX_COMPONENTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // [31:0] entry_start, [63:32] entry_end, [95:64] query_start,
  // [127:96] query_end
  input  wire logic [ioq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [ioq_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                            in_tlast,   // closes_component
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] match_start, [63:32] match_end
  output      logic [ioq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] found
  output      logic [0:0]                      out_tuser,
  output      logic                            out_tlast   // last_result
);
  import ioq_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CC_W  = $clog2(MAX_COMPONENTS + 1);
  localparam int CI_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_COMP = 10'b00_0000_0010,  // fetch component descriptor
    S_SCAN = 10'b00_0000_0100,  // short component, upward scan
    S_BR   = 10'b00_0000_1000,  // search: check last entry
    S_BL   = 10'b00_0001_0000,  // search: check first entry
    S_BMID = 10'b00_0010_0000,  // search: bisect step
    S_BFR  = 10'b00_0100_0000,  // search: final right
    S_BFL  = 10'b00_1000_0000,  // search: final left
    S_WALK = 10'b01_0000_0000,  // long component, downward walk
    S_DONE = 10'b10_0000_0000   // release held match / none found
  } state_t;

  // field split
  logic [COORD_W-1:0] f_start, f_end, f_qs, f_qe;
  assign f_start = in_tdata[COORD_W-1:0];
  assign f_end   = in_tdata[2*COORD_W-1:COORD_W];
  assign f_qs    = in_tdata[3*COORD_W-1:2*COORD_W];
  assign f_qe    = in_tdata[4*COORD_W-1:3*COORD_W];

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  entry_count_r;
  logic [CC_W-1:0]   comp_count_r;
  logic [CNT_W-1:0]  open_first_r;
  logic [COORD_W-1:0] prev_rmax_r;

  // component table
  logic [CNT_W-1:0]  comp_first_r [MAX_COMPONENTS];
  logic [CNT_W-1:0]  comp_len_r   [MAX_COMPONENTS];

  // query context
  logic [COORD_W-1:0] qs_r, qe_r;
  logic [CC_W-1:0]    k_r, k_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   t_r, t_nxt;
  logic [IDX_W-1:0]   left_r, left_nxt;
  logic [IDX_W-1:0]   right_r, right_nxt;
  logic [IDX_W-1:0]   cs_r, cs_nxt;
  logic [IDX_W-1:0]   ce_r, ce_nxt;

  // holding stage and output register
  logic               pend_v_r;
  logic [COORD_W-1:0] pend_start_r, pend_end_r;
  logic               out_valid_r, out_found_r, out_last_r;
  logic [COORD_W-1:0] out_start_r, out_end_r;

  entry_t rd_data;
  entry_t wr_data;
  logic   wr_en;

  logic accept, out_free, emit_req, can_take, stall;
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign can_take = !pend_v_r || out_free;
  assign stall    = emit_req && !can_take;

  // ---------------- load path ----------------
  logic             load_ok;
  logic [CNT_W-1:0] entry_inc;
  logic [COORD_W-1:0] new_rmax;
  assign load_ok   = accept && (in_tuser == OP_LOAD) && (f_start <= f_end) &&
                     (entry_count_r < CNT_W'(STORE_DEPTH)) &&
                     (comp_count_r < CC_W'(MAX_COMPONENTS));
  assign entry_inc = entry_count_r + 1'b1;

  always_comb begin
    if ((entry_count_r == open_first_r) || (entry_count_r == '0)) begin
      new_rmax = f_end;
    end else begin
      new_rmax = (prev_rmax_r > f_end) ? prev_rmax_r : f_end;
    end
  end

  assign wr_en             = load_ok;
  assign wr_data.ent_start = f_start;
  assign wr_data.ent_end   = f_end;
  assign wr_data.ent_rmax  = new_rmax;

  ioq_store #(
    .DEPTH (STORE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (addr_nxt),
    .rd_data (rd_data)
  );

  // ---------------- query sequencer ----------------
  logic [CNT_W-1:0] cd_first, cd_len, cd_last;
  logic             st_below, end_above, rmax_above;
  logic [IDX_W-1:0] bs_l, bs_r;
  logic             bs_step, go_next;
  logic [IDX_W:0]   mid_sum;

  assign cd_first   = comp_first_r[k_r[CI_W-1:0]];
  assign cd_len     = comp_len_r[k_r[CI_W-1:0]];
  assign cd_last    = cd_first + cd_len - 1'b1;
  assign st_below   = rd_data.ent_start < qe_r;
  assign end_above  = rd_data.ent_end > qs_r;
  assign rmax_above = rd_data.ent_rmax > qs_r;
  assign mid_sum    = {1'b0, bs_l} + {1'b0, bs_r};

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    t_nxt     = t_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    k_nxt     = k_r;
    cs_nxt    = cs_r;
    ce_nxt    = ce_r;
    emit_req  = 1'b0;
    go_next   = 1'b0;
    bs_step   = 1'b0;
    bs_l      = left_r;
    bs_r      = right_r;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_tuser == OP_QUERY)) begin
          k_nxt     = '0;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (k_r == comp_count_r) begin
          state_nxt = S_DONE;
        end else begin
          cs_nxt = cd_first[IDX_W-1:0];
          ce_nxt = cd_last[IDX_W-1:0];
          if (cd_len > CNT_W'(LONG_COMPONENT)) begin
            left_nxt  = cd_first[IDX_W-1:0];
            right_nxt = cd_last[IDX_W-1:0];
            addr_nxt  = cd_last[IDX_W-1:0];
            state_nxt = S_BR;
          end else begin
            t_nxt     = cd_first[IDX_W-1:0];
            addr_nxt  = cd_first[IDX_W-1:0];
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        emit_req = st_below && end_above;
        if (t_r == ce_r) begin
          go_next = 1'b1;
        end else begin
          t_nxt    = t_r + 1'b1;
          addr_nxt = t_r + 1'b1;
        end
      end
      S_BR: begin
        if (st_below) begin
          t_nxt     = right_r;
          state_nxt = S_WALK;
        end else begin
          addr_nxt  = left_r;
          state_nxt = S_BL;
        end
      end
      S_BL: begin
        if (!st_below) begin
          go_next = 1'b1;
        end else begin
          bs_step = 1'b1;
        end
      end
      S_BMID: begin
        bs_step = 1'b1;
        if (!st_below) begin
          bs_r = addr_r - 1'b1;
        end else begin
          bs_l = addr_r;
        end
      end
      S_BFR: begin
        if (st_below) begin
          t_nxt     = right_r;
          addr_nxt  = right_r;
          state_nxt = S_WALK;
        end else begin
          addr_nxt  = left_r;
          state_nxt = S_BFL;
        end
      end
      S_BFL: begin
        if (st_below) begin
          t_nxt     = left_r;
          addr_nxt  = left_r;
          state_nxt = S_WALK;
        end else begin
          go_next = 1'b1;
        end
      end
      S_WALK: begin
        if (rmax_above) begin
          emit_req = end_above;
          if (t_r == cs_r) begin
            go_next = 1'b1;
          end else begin
            t_nxt    = t_r - 1'b1;
            addr_nxt = t_r - 1'b1;
          end
        end else begin
          go_next = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one bisect decision: keep halving while the window spans 3+ entries
    if (bs_step) begin
      left_nxt  = bs_l;
      right_nxt = bs_r;
      if (({1'b0, bs_l} + 1'b1) < {1'b0, bs_r}) begin
        addr_nxt  = mid_sum[IDX_W:1];
        state_nxt = S_BMID;
      end else begin
        addr_nxt  = bs_r;
        state_nxt = S_BFR;
      end
    end

    if (go_next) begin
      k_nxt     = k_r + 1'b1;
      state_nxt = S_COMP;
    end

    // match with nowhere to go: freeze and keep re-reading the same entry
    if (emit_req && !can_take) begin
      state_nxt = state_r;
      addr_nxt  = addr_r;
      t_nxt     = t_r;
      k_nxt     = k_r;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      comp_count_r  <= '0;
      open_first_r  <= '0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (accept && (in_tuser == OP_CLEAR)) begin
        entry_count_r <= '0;
        comp_count_r  <= '0;
        open_first_r  <= '0;
      end else if (load_ok) begin
        entry_count_r <= entry_inc;
        if (in_tlast) begin
          comp_count_r <= comp_count_r + 1'b1;
          open_first_r <= entry_inc;
        end
      end

      // output register
      if (emit_req && pend_v_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // holding stage
      if (emit_req && can_take) begin
        pend_v_r <= 1'b1;
      end else if ((state_r == S_DONE) && out_free) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      prev_rmax_r <= new_rmax;
      if (in_tlast) begin
        comp_first_r[comp_count_r[CI_W-1:0]] <= open_first_r;
        comp_len_r[comp_count_r[CI_W-1:0]]   <= entry_inc - open_first_r;
      end
    end
    if (accept && (in_tuser == OP_QUERY)) begin
      qs_r <= f_qs;
      qe_r <= f_qe;
    end
    k_r     <= k_nxt;
    addr_r  <= addr_nxt;
    t_r     <= t_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    cs_r    <= cs_nxt;
    ce_r    <= ce_nxt;

    if (emit_req && can_take) begin
      pend_start_r <= rd_data.ent_start;
      pend_end_r   <= rd_data.ent_end;
    end

    if (emit_req && pend_v_r && out_free) begin
      out_start_r <= pend_start_r;
      out_end_r   <= pend_end_r;
      out_found_r <= 1'b1;
      out_last_r  <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_start_r <= pend_v_r ? pend_start_r : '0;
      out_end_r   <= pend_v_r ? pend_end_r : '0;
      out_found_r <= pend_v_r;
      out_last_r  <= 1'b1;
    end
  end

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_end_r, out_start_r};
  assign out_tuser[0] = out_found_r;
  assign out_tlast    = out_last_r;

  // ---------------- assertions ----------------
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held match left over after query end");

  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_count_r <= CNT_W'(STORE_DEPTH)) && (open_first_r <= entry_count_r))
    else $error("entry count out of range");

  a_comp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    comp_count_r <= CC_W'(MAX_COMPONENTS))
    else $error("component count out of range");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=> (out_valid_r && out_last_r))
    else $error("query closed without final response");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> ($stable(addr_r) && $stable(state_r)))
    else $error("sequencer moved during stall");

endmodule
`default_nettype wire

>>> sv/ioq_store.sv
`default_nettype none
module ioq_store #(
  parameter int DEPTH = ioq_pkg::DEF_STORE_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire ioq_pkg::entry_t     wr_data,
  input  wire logic [IDX_W-1:0]    rd_addr,
  output      ioq_pkg::entry_t     rd_data
);
  import ioq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, one address per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
